// File: sv/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg: shared types and constants
// Widths, operation codes, sequencer states and cell control for the
// bucketed histogram percentile unit.
// ----------------------------------------------------------------------------
package bhp_pkg;

    localparam int MAX_BOUNDS  = 7;
    localparam int NUM_BUCKETS = MAX_BOUNDS + 1;
    localparam int COUNT_BITS  = 32;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 64;
    localparam int POINT_W     = 14;
    localparam int CUM_W       = COUNT_BITS + IDX_W;     // sum of all bucket counts
    localparam int C10K_W      = CUM_W + POINT_W;        // cumulative count * scale
    localparam int FRAC_W      = COUNT_BITS + POINT_W;   // target, numerator, denominator
    localparam int MAG_W       = VAL_W + 1;              // bound difference magnitude
    localparam int DIVD_W      = 80;                     // divider dividend / quotient
    localparam int DIVS_W      = 48;                     // divider divisor / remainder
    localparam int MCNT_W      = 6;
    localparam int BASE_W      = VAL_W + 4;

    localparam logic [POINT_W-1:0]  POINT_SCALE = 14'd10000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [MCNT_W-1:0]   MUL_STEPS   = 6'(FRAC_W);

    localparam logic [IDX_W-1:0] REG_BOUND_COUNT = 3'd0;

    typedef enum logic [1:0]
    {
        OP_OBSERVE = 2'd0,
        OP_QUERY   = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_OBS,
        S_PCT_TGT,
        S_WALK,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_AVG_GO,
        S_AVG_WAIT,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic active;    // bucket has a bound in use
        logic is_end;    // bucket is the overflow bucket
        logic inc;       // count the sample
        logic bound_we;  // configuration write of the bound
    } cell_ctrl_t;

endpackage

// File: sv/bhp_in_if.sv
// ----------------------------------------------------------------------------
// bhp_in_if: input item channel
// Valid/ready channel carrying one histogram operation.
// ----------------------------------------------------------------------------
interface bhp_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [bhp_pkg::VAL_W-1:0]    sample_value;
    logic [bhp_pkg::POINT_W-1:0]  percentile_point;
    logic [bhp_pkg::IDX_W-1:0]    bucket_select;

    modport source (output valid, op, sample_value, percentile_point, bucket_select,
                    input ready);
    modport sink   (input valid, op, sample_value, percentile_point, bucket_select,
                    output ready);
endinterface

// File: sv/bhp_out_if.sv
// ----------------------------------------------------------------------------
// bhp_out_if: result item channel
// Valid/ready channel carrying one result with the summary statistics.
// ----------------------------------------------------------------------------
interface bhp_out_if;
    logic                            valid;
    logic                            ready;
    logic [bhp_pkg::IDX_W-1:0]       bucket_index;
    logic [bhp_pkg::COUNT_BITS-1:0]  bucket_total;
    logic [bhp_pkg::COUNT_BITS-1:0]  sample_count;
    logic signed [bhp_pkg::SUM_W-1:0] sample_sum;
    logic signed [bhp_pkg::VAL_W-1:0] smallest;
    logic signed [bhp_pkg::VAL_W-1:0] largest;
    logic signed [bhp_pkg::VAL_W-1:0] average;
    logic signed [bhp_pkg::VAL_W-1:0] percentile_value;

    modport source (output valid, bucket_index, bucket_total, sample_count, sample_sum,
                    smallest, largest, average, percentile_value, input ready);
    modport sink   (input valid, bucket_index, bucket_total, sample_count, sample_sum,
                    smallest, largest, average, percentile_value, output ready);
endinterface

// File: sv/bhp_cfg_if.sv
// ----------------------------------------------------------------------------
// bhp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bhp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bhp_pkg::IDX_W-1:0]  index;
    logic [bhp_pkg::VAL_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/bhp_cell.sv
// ----------------------------------------------------------------------------
// bhp_cell: one histogram bucket
// Holds a bucket bound and its saturating count; claims a sample at or below
// its bound (the end bucket claims any) when no earlier cell in the row has.
// ----------------------------------------------------------------------------
module bhp_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bhp_pkg::cell_ctrl_t             ctrl,
    input  logic [bhp_pkg::VAL_W-1:0]       bound_data,
    input  logic [bhp_pkg::VAL_W-1:0]       sample,
    input  logic                            found_in,
    output logic                            found_out,
    output logic                            hit,
    output logic [bhp_pkg::COUNT_BITS-1:0]  count,
    output logic [bhp_pkg::VAL_W-1:0]       bound
);

    logic [bhp_pkg::VAL_W-1:0]      bound_reg;
    logic [bhp_pkg::COUNT_BITS-1:0] count_reg;

    assign hit       = !found_in &&
                       (ctrl.is_end || (ctrl.active && $signed(sample) <= $signed(bound_reg)));
    assign found_out = found_in || hit;
    assign count     = count_reg;
    assign bound     = bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.bound_we)
            begin
                bound_reg <= bound_data;
            end
            // hold at the ceiling
            if (ctrl.inc && count_reg != bhp_pkg::COUNT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

endmodule

// File: sv/bhp_div.sv
// ----------------------------------------------------------------------------
// bhp_div: shared restoring divider
// One quotient bit per cycle; done pulses when quotient and remainder hold.
// ----------------------------------------------------------------------------
module bhp_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bhp_pkg::DIVD_W-1:0]    dividend,
    input  logic [bhp_pkg::DIVS_W-1:0]    divisor,
    output logic                          busy,
    output logic                          done,
    output logic [bhp_pkg::DIVD_W-1:0]    quotient,
    output logic [bhp_pkg::DIVS_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(bhp_pkg::DIVD_W + 1);

    logic [bhp_pkg::DIVD_W-1:0] quo_reg;
    logic [bhp_pkg::DIVS_W-1:0] rem_reg;
    logic [bhp_pkg::DIVS_W-1:0] dsr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [bhp_pkg::DIVS_W:0]   trial;
    logic                       take;

    assign trial     = {rem_reg, quo_reg[bhp_pkg::DIVD_W-1]};
    assign take      = trial >= {1'b0, dsr_reg};
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(bhp_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[bhp_pkg::DIVD_W-2:0], take};
            rem_reg <= take ? bhp_pkg::DIVS_W'(trial - {1'b0, dsr_reg})
                            : bhp_pkg::DIVS_W'(trial);
        end
    end

endmodule

// File: sv/bucketed_histogram_percentile_unit.sv
// ----------------------------------------------------------------------------
// bucketed_histogram_percentile_unit: histogram with percentile estimate
// Counts signed samples into bounded buckets and answers percentile queries.
// ----------------------------------------------------------------------------
// Usage:
//   items   - valid/ready input: op 0 observes sample_value, op 1 asks for
//             percentile_point (hundredths of a percent), op 2 reads the
//             count of bucket_select. One result per item on results.
//   cfg     - valid/ready write port, always ready: index 0 is bound_count,
//             index 1..7 are the inclusive bucket bounds. Write only when idle.
//   One item is worked on at a time. With samples held, an observe, a bucket
//   read or a no-op waits on the 80-step restoring divider that forms the
//   mean; with no samples the mean is skipped. A query walks the bucket row
//   one cell a cycle and then runs at most a 46-step shift-add multiply and
//   two passes of the same divider.
//   The result register parts the two sides: the next item is taken while a
//   result still waits; a stalled receiver holds the unit in its final step.
//   Reset clears all counts and statistics, sets bound_count to 7 and every
//   bound to 0.
// ----------------------------------------------------------------------------
module bucketed_histogram_percentile_unit
(
    input  logic        clk,
    input  logic        rst_n,
    bhp_in_if.sink      items,
    bhp_out_if.source   results,
    bhp_cfg_if.sink     cfg
);

    localparam int NB = bhp_pkg::NUM_BUCKETS;
    localparam int VW = bhp_pkg::VAL_W;

    bhp_pkg::state_t state_reg, state_next;

    logic [1:0]                     op_reg;
    logic [VW-1:0]                  sample_reg;
    logic [bhp_pkg::POINT_W-1:0]    point_reg;
    logic [bhp_pkg::IDX_W-1:0]      idx_reg;
    logic [bhp_pkg::IDX_W-1:0]      bc_reg;

    logic [bhp_pkg::COUNT_BITS-1:0] total_reg;
    logic [bhp_pkg::SUM_W-1:0]      sum_reg;
    logic [VW-1:0]                  min_reg;
    logic [VW-1:0]                  max_reg;

    logic [bhp_pkg::IDX_W-1:0]      walk_reg;
    logic [bhp_pkg::CUM_W-1:0]      cum_reg;
    logic [bhp_pkg::C10K_W-1:0]     prev10k_reg;
    logic [bhp_pkg::FRAC_W-1:0]     target_reg;
    logic [VW-1:0]                  prevb_reg;
    logic [bhp_pkg::MAG_W-1:0]      mag_reg;
    logic                           neg_reg;
    logic [bhp_pkg::FRAC_W-1:0]     num_reg;
    logic [bhp_pkg::FRAC_W-1:0]     den_reg;
    logic [bhp_pkg::DIVD_W-1:0]     acc_reg;
    logic [bhp_pkg::MCNT_W-1:0]     mcnt_reg;
    logic [VW-1:0]                  pval_reg;
    logic [VW-1:0]                  avg_reg;

    logic                           out_valid_reg;
    logic [bhp_pkg::IDX_W-1:0]      o_idx_reg;
    logic [bhp_pkg::COUNT_BITS-1:0] o_btot_reg;
    logic [bhp_pkg::COUNT_BITS-1:0] o_cnt_reg;
    logic [bhp_pkg::SUM_W-1:0]      o_sum_reg;
    logic [VW-1:0]                  o_min_reg;
    logic [VW-1:0]                  o_max_reg;
    logic [VW-1:0]                  o_avg_reg;
    logic [VW-1:0]                  o_pval_reg;

    // bucket row
    bhp_pkg::cell_ctrl_t            cell_ctrl [NB];
    logic [NB:0]                    found;
    logic [NB-1:0]                  hit;
    logic [bhp_pkg::COUNT_BITS-1:0] cell_count [NB];
    logic [VW-1:0]                  cell_bound [NB];
    logic [bhp_pkg::IDX_W-1:0]      used_n;
    logic [bhp_pkg::IDX_W-1:0]      hit_idx;
    logic [bhp_pkg::IDX_W-1:0]      rd_addr;
    logic [bhp_pkg::COUNT_BITS-1:0] rd_count;
    logic [VW-1:0]                  rd_bound;

    // walk step
    logic [bhp_pkg::CUM_W-1:0]      cum_new;
    logic [bhp_pkg::C10K_W-1:0]     c10k;
    logic                           reached;
    logic [VW:0]                    diff;
    logic [bhp_pkg::FRAC_W-1:0]     den_new;

    // statistics update
    logic [bhp_pkg::SUM_W:0]        sum_wide;
    logic [bhp_pkg::SUM_W-1:0]      sum_sat;
    logic [bhp_pkg::SUM_W-1:0]      sum_mag;

    // divider
    logic                           div_start;
    logic [bhp_pkg::DIVD_W-1:0]     div_dividend;
    logic [bhp_pkg::DIVS_W-1:0]     div_divisor;
    logic                           div_busy;
    logic                           div_done;
    logic [bhp_pkg::DIVD_W-1:0]     div_quo;
    logic [bhp_pkg::DIVS_W-1:0]     div_rem;

    // interpolation fix-up
    logic                           rem_nz;
    logic [bhp_pkg::BASE_W-1:0]     base_raw;
    logic [bhp_pkg::BASE_W-1:0]     base_fix;
    logic [VW-1:0]                  avg_val;

    logic                           out_load;
    logic                           accept;

    assign accept    = items.valid && items.ready;
    assign items.ready = (state_reg == bhp_pkg::S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == bhp_pkg::S_DONE) && (!out_valid_reg || results.ready);

    assign used_n = (bc_reg > bhp_pkg::IDX_W'(bhp_pkg::MAX_BOUNDS))
                  ? bhp_pkg::IDX_W'(bhp_pkg::MAX_BOUNDS) : bc_reg;

    assign found[0] = 1'b0;

    for (genvar g = 0; g < NB; g++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[g].active   = bhp_pkg::IDX_W'(g) < used_n;
            cell_ctrl[g].is_end   = bhp_pkg::IDX_W'(g) == used_n;
            cell_ctrl[g].inc      = (state_reg == bhp_pkg::S_OBS) && hit[g];
            cell_ctrl[g].bound_we = cfg.valid && cfg.ready &&
                                    cfg.index != bhp_pkg::REG_BOUND_COUNT &&
                                    (cfg.index - 1'b1) == bhp_pkg::IDX_W'(g);
        end

        bhp_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .bound_data (cfg.data),
            .sample     (sample_reg),
            .found_in   (found[g]),
            .found_out  (found[g+1]),
            .hit        (hit[g]),
            .count      (cell_count[g]),
            .bound      (cell_bound[g])
        );
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < NB; i++)
        begin
            if (hit[i])
            begin
                hit_idx = bhp_pkg::IDX_W'(i);
            end
        end
    end

    assign rd_addr  = (state_reg == bhp_pkg::S_WALK) ? walk_reg : idx_reg;
    assign rd_count = cell_count[rd_addr];
    assign rd_bound = cell_bound[rd_addr];

    assign cum_new = cum_reg + bhp_pkg::CUM_W'(rd_count);
    assign c10k    = bhp_pkg::C10K_W'(cum_new) * bhp_pkg::C10K_W'(bhp_pkg::POINT_SCALE);
    assign reached = c10k >= bhp_pkg::C10K_W'(target_reg);
    assign diff    = {rd_bound[VW-1], rd_bound} - {prevb_reg[VW-1], prevb_reg};
    assign den_new = bhp_pkg::FRAC_W'(c10k - prev10k_reg);

    assign sum_wide = {sum_reg[bhp_pkg::SUM_W-1], sum_reg}
                    + {{(bhp_pkg::SUM_W-VW+1){sample_reg[VW-1]}}, sample_reg};
    always_comb
    begin
        if (sum_wide[bhp_pkg::SUM_W] != sum_wide[bhp_pkg::SUM_W-1])
        begin
            sum_sat = sum_wide[bhp_pkg::SUM_W] ? {1'b1, {(bhp_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(bhp_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[bhp_pkg::SUM_W-1:0];
        end
    end
    assign sum_mag = sum_reg[bhp_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    assign div_start    = ((state_reg == bhp_pkg::S_AVG_GO) && total_reg != '0) ||
                          (state_reg == bhp_pkg::S_DIV_GO);
    assign div_dividend = (state_reg == bhp_pkg::S_AVG_GO)
                        ? bhp_pkg::DIVD_W'(sum_mag) : acc_reg;
    assign div_divisor  = (state_reg == bhp_pkg::S_AVG_GO)
                        ? bhp_pkg::DIVS_W'(total_reg) : bhp_pkg::DIVS_W'(den_reg);

    bhp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // truncate toward zero: step a negative base with a remainder back up
    assign rem_nz = div_rem != '0;
    always_comb
    begin
        if (neg_reg)
        begin
            base_raw = {{(bhp_pkg::BASE_W-VW){prevb_reg[VW-1]}}, prevb_reg}
                     - bhp_pkg::BASE_W'(div_quo[bhp_pkg::MAG_W:0])
                     - bhp_pkg::BASE_W'(rem_nz);
        end
        else
        begin
            base_raw = {{(bhp_pkg::BASE_W-VW){prevb_reg[VW-1]}}, prevb_reg}
                     + bhp_pkg::BASE_W'(div_quo[bhp_pkg::MAG_W:0]);
        end
        base_fix = (rem_nz && base_raw[bhp_pkg::BASE_W-1]) ? base_raw + 1'b1 : base_raw;
    end

    always_comb
    begin
        if (sum_reg[bhp_pkg::SUM_W-1])
        begin
            avg_val = (|div_quo[bhp_pkg::DIVD_W-1:VW-1]) ? {1'b1, {(VW-1){1'b0}}}
                                                         : ~div_quo[VW-1:0] + 1'b1;
        end
        else
        begin
            avg_val = (|div_quo[bhp_pkg::DIVD_W-1:VW-1]) ? {1'b0, {(VW-1){1'b1}}}
                                                         : div_quo[VW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bhp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (items.op)
                        bhp_pkg::OP_OBSERVE: state_next = bhp_pkg::S_OBS;
                        bhp_pkg::OP_QUERY:   state_next = bhp_pkg::S_PCT_TGT;
                        default:             state_next = bhp_pkg::S_AVG_GO;
                    endcase
                end
            end
            bhp_pkg::S_OBS:     state_next = bhp_pkg::S_AVG_GO;
            bhp_pkg::S_PCT_TGT:
            begin
                state_next = (total_reg == '0) ? bhp_pkg::S_AVG_GO : bhp_pkg::S_WALK;
            end
            bhp_pkg::S_WALK:
            begin
                if (walk_reg >= used_n)
                begin
                    state_next = bhp_pkg::S_AVG_GO;
                end
                else if (reached)
                begin
                    state_next = (den_new == '0) ? bhp_pkg::S_AVG_GO : bhp_pkg::S_MUL;
                end
            end
            bhp_pkg::S_MUL:
            begin
                if (mcnt_reg == bhp_pkg::MCNT_W'(1))
                begin
                    state_next = bhp_pkg::S_DIV_GO;
                end
            end
            bhp_pkg::S_DIV_GO:  state_next = bhp_pkg::S_DIV_WAIT;
            bhp_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = bhp_pkg::S_AVG_GO;
                end
            end
            bhp_pkg::S_AVG_GO:
            begin
                state_next = (total_reg == '0) ? bhp_pkg::S_DONE : bhp_pkg::S_AVG_WAIT;
            end
            bhp_pkg::S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = bhp_pkg::S_DONE;
                end
            end
            bhp_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = bhp_pkg::S_IDLE;
                end
            end
            default:            state_next = bhp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bhp_pkg::S_IDLE;
            bc_reg        <= bhp_pkg::IDX_W'(bhp_pkg::MAX_BOUNDS);
            total_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= {1'b0, {(VW-1){1'b1}}};
            max_reg       <= {1'b1, {(VW-1){1'b0}}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready && cfg.index == bhp_pkg::REG_BOUND_COUNT)
            begin
                bc_reg <= cfg.data[bhp_pkg::IDX_W-1:0];
            end
            if (state_reg == bhp_pkg::S_OBS)
            begin
                if (total_reg != bhp_pkg::COUNT_MAX)
                begin
                    total_reg <= total_reg + 1'b1;
                end
                sum_reg <= sum_sat;
                if ($signed(sample_reg) < $signed(min_reg))
                begin
                    min_reg <= sample_reg;
                end
                if ($signed(sample_reg) > $signed(max_reg))
                begin
                    max_reg <= sample_reg;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bhp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_reg     <= items.op;
                    sample_reg <= items.sample_value;
                    point_reg  <= items.percentile_point;
                    idx_reg    <= (items.op == bhp_pkg::OP_READ) ? items.bucket_select : '0;
                    pval_reg   <= '0;
                end
            end
            bhp_pkg::S_OBS:
            begin
                idx_reg <= hit_idx;
            end
            bhp_pkg::S_PCT_TGT:
            begin
                target_reg  <= bhp_pkg::FRAC_W'(total_reg) * bhp_pkg::FRAC_W'(point_reg);
                cum_reg     <= '0;
                prev10k_reg <= '0;
                prevb_reg   <= '0;
                walk_reg    <= '0;
            end
            bhp_pkg::S_WALK:
            begin
                if (walk_reg >= used_n)
                begin
                    pval_reg <= max_reg;
                end
                else if (reached)
                begin
                    pval_reg <= prevb_reg;
                    neg_reg  <= diff[VW];
                    mag_reg  <= diff[VW] ? (~diff + 1'b1) : diff;
                    num_reg  <= target_reg - bhp_pkg::FRAC_W'(prev10k_reg);
                    den_reg  <= den_new;
                    acc_reg  <= '0;
                    mcnt_reg <= bhp_pkg::MUL_STEPS;
                end
                else
                begin
                    cum_reg     <= cum_new;
                    prev10k_reg <= c10k;
                    prevb_reg   <= rd_bound;
                    walk_reg    <= walk_reg + 1'b1;
                end
            end
            bhp_pkg::S_MUL:
            begin
                acc_reg  <= {acc_reg[bhp_pkg::DIVD_W-2:0], 1'b0}
                          + (num_reg[bhp_pkg::FRAC_W-1] ? bhp_pkg::DIVD_W'(mag_reg) : '0);
                num_reg  <= {num_reg[bhp_pkg::FRAC_W-2:0], 1'b0};
                mcnt_reg <= mcnt_reg - 1'b1;
            end
            bhp_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    pval_reg <= base_fix[VW-1:0];
                end
            end
            bhp_pkg::S_AVG_GO:
            begin
                avg_reg <= '0;
            end
            bhp_pkg::S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_reg <= avg_val;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            o_idx_reg  <= idx_reg;
            o_btot_reg <= (op_reg == bhp_pkg::OP_OBSERVE || op_reg == bhp_pkg::OP_READ)
                        ? rd_count : '0;
            o_cnt_reg  <= total_reg;
            o_sum_reg  <= sum_reg;
            o_min_reg  <= (total_reg != '0) ? min_reg : '0;
            o_max_reg  <= (total_reg != '0) ? max_reg : '0;
            o_avg_reg  <= avg_reg;
            o_pval_reg <= pval_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.bucket_index     = o_idx_reg;
    assign results.bucket_total     = o_btot_reg;
    assign results.sample_count     = o_cnt_reg;
    assign results.sample_sum       = o_sum_reg;
    assign results.smallest         = o_min_reg;
    assign results.largest          = o_max_reg;
    assign results.average          = o_avg_reg;
    assign results.percentile_value = o_pval_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !items.ready)
        else $error("input ready while an item is in progress");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("sample count went down");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0 |-> $signed(min_reg) <= $signed(max_reg))
        else $error("minimum above maximum with samples present");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bhp_pkg::S_OBS |-> $onehot(hit))
        else $error("sample claimed by no bucket or by several");

endmodule
